@@ design/vector_angle_full_circle_macros.svh @@
// Assertion macros shared by the vector angle design.
// No dependencies; included by the files that carry assertions.
`ifndef VECTOR_ANGLE_FULL_CIRCLE_MACROS_SVH
`define VECTOR_ANGLE_FULL_CIRCLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define VAFC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Implication after a fixed number of cycles, disabled in reset.
`define VAFC_ASSERT_DLY(name, clk, rst_n, ante, lat, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
		else $error("%m: delayed check failed");

`endif

@@ design/vafc_pkg.sv @@
// Package for the vector angle pipeline: widths, stage count, arctangent table.
// No dependencies.
package vafc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	// stages beyond the table add nothing
	localparam int NSTG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

	localparam int XW = 27;  // CORDIC x/y width: 2^23 magnitude times gain
	localparam int ZW = 25;  // angle accumulator, 2^-24 turn units

	// input register, NSTG rotations, round stage, output register
	localparam int LATENCY = NSTG + 3;

	localparam logic [15:0] ANG_ZERO    = 16'd0;
	localparam logic [15:0] ANG_QUARTER = 16'd16384;
	localparam logic [15:0] ANG_HALF    = 16'd32768;
	localparam logic [15:0] ANG_3QUART  = 16'd49152;

	typedef struct packed {
		logic        spec;      // axis or zero vector, angle decoded directly
		logic [15:0] spec_ang;
		logic        neg_x;
		logic        neg_z;
	} meta_t;

	// round(atan(2^-i) * 2^24 / (2*pi))
	function automatic logic [21:0] atan_turn(input int i);
		logic [21:0] r;
		case (i)
			0:  r = 22'd2097152;
			1:  r = 22'd1238021;
			2:  r = 22'd654136;
			3:  r = 22'd332050;
			4:  r = 22'd166669;
			5:  r = 22'd83416;
			6:  r = 22'd41718;
			7:  r = 22'd20860;
			8:  r = 22'd10430;
			9:  r = 22'd5215;
			10: r = 22'd2608;
			11: r = 22'd1304;
			12: r = 22'd652;
			13: r = 22'd326;
			14: r = 22'd163;
			15: r = 22'd81;
			16: r = 22'd41;
			17: r = 22'd20;
			18: r = 22'd10;
			19: r = 22'd5;
			20: r = 22'd3;
			21: r = 22'd1;
			22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

@@ design/vector_angle_full_circle.sv @@
// Top level: full-circle angle of a planar vector, pipelined CORDIC vectoring.
// Depends on vafc_pkg and vector_angle_full_circle_macros.svh.
//
//  channel   signals               direction  accepted when
//  input     start, busy, dx, dz   in (busy out)  start high and busy low at clk edge
//  result    done, angle           out        done high (one cycle, no backpressure)
//
// One item may enter every cycle; busy is held low.
// The path runs through the input register, one register stage per
// CORDIC rotation, a clamp/round stage and the quadrant fold into the output register.
// arst_n clears all valid bits; items in flight are dropped.
// Nothing stalls: the receiver must take done/angle in the cycle shown.
`include "vector_angle_full_circle_macros.svh"

module vector_angle_full_circle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] dx,
	input  logic signed [15:0] dz,
	output logic               done,
	output logic        [15:0] angle
);

	localparam int N  = vafc_pkg::NSTG;
	localparam int XW = vafc_pkg::XW;
	localparam int ZW = vafc_pkg::ZW;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---- input decode: magnitudes, quadrant, axis cases
	logic signed [16:0] dxe, dze, ax, az;
	vafc_pkg::meta_t    meta_in;

	always_comb begin
		dxe = {dx[15], dx};
		dze = {dz[15], dz};
		ax  = dxe[16] ? -dxe : dxe;
		az  = dze[16] ? -dze : dze;
		meta_in.neg_x    = dx[15];
		meta_in.neg_z    = dz[15];
		meta_in.spec     = (dx == 16'sd0) || (dz == 16'sd0);
		if (dx == 16'sd0 && dz == 16'sd0) begin
			meta_in.spec_ang = vafc_pkg::ANG_ZERO;
		end else if (dx == 16'sd0) begin
			meta_in.spec_ang = dz[15] ? vafc_pkg::ANG_3QUART : vafc_pkg::ANG_QUARTER;
		end else begin
			meta_in.spec_ang = dx[15] ? vafc_pkg::ANG_HALF : vafc_pkg::ANG_ZERO;
		end
	end

	// CORDIC pipe: index 0 is the input register, index k+1 follows rotation k
	logic                  cv_s [0:N];
	logic signed [XW-1:0]  cx_s [0:N];
	logic signed [XW-1:0]  cy_s [0:N];
	logic signed [ZW-1:0]  cz_s [0:N];
	vafc_pkg::meta_t       cm_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else begin
			cv_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0] <= {{(XW-25){1'b0}}, ax[15:0] == 16'd0 && ax[16] ? 1'b1 : ax[16],
			ax[15:0], 8'd0};
		cy_s[0] <= {{(XW-25){1'b0}}, az[16], az[15:0], 8'd0};
		cz_s[0] <= '0;
		cm_s[0] <= meta_in;
	end

	for (genvar k = 0; k < N; k++) begin : g_rot
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] at;
		assign xs = cx_s[k] >>> k;
		assign ys = cy_s[k] >>> k;
		assign at = ZW'(vafc_pkg::atan_turn(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k+1] <= 1'b0;
			end else begin
				cv_s[k+1] <= cv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (!cy_s[k][XW-1]) begin
				cx_s[k+1] <= cx_s[k] + ys;
				cy_s[k+1] <= cy_s[k] - xs;
				cz_s[k+1] <= cz_s[k] + at;
			end else begin
				cx_s[k+1] <= cx_s[k] - ys;
				cy_s[k+1] <= cy_s[k] + xs;
				cz_s[k+1] <= cz_s[k] - at;
			end
			cm_s[k+1] <= cm_s[k];
		end
	end

	// ---- clamp to 0..2^22 and round to binary angle units (0..16384)
	logic [22:0]      zc, zr;
	logic             v_sr;
	logic [14:0]      a_sr;
	vafc_pkg::meta_t  m_sr;

	always_comb begin
		if (cz_s[N][ZW-1]) begin
			zc = '0;
		end else if (cz_s[N] > ZW'(24'sd4194304)) begin
			zc = 23'd4194304;
		end else begin
			zc = cz_s[N][22:0];
		end
		zr = zc + 23'd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= 1'b0;
		end else begin
			v_sr <= cv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		a_sr <= zr[22:8];
		m_sr <= cm_s[N];
	end

	// ---- quadrant fold, modulo a full turn; axis and zero vectors use spec_ang
	logic [15:0] a16, fold;

	always_comb begin
		a16 = {1'b0, a_sr};
		if (m_sr.spec) begin
			fold = m_sr.spec_ang;
		end else if (!m_sr.neg_x && !m_sr.neg_z) begin
			fold = a16;
		end else if (m_sr.neg_x && !m_sr.neg_z) begin
			fold = vafc_pkg::ANG_HALF - a16;
		end else if (m_sr.neg_x) begin
			fold = vafc_pkg::ANG_HALF + a16;
		end else begin
			fold = vafc_pkg::ANG_ZERO - a16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_sr;
		end
	end

	always_ff @(posedge clk) begin
		angle <= fold;
	end

	// ---- assertions
	`VAFC_ASSERT_DLY(a_latency, clk, arst_n, accept, vafc_pkg::LATENCY, done)
	`VAFC_ASSERT_IMP(a_no_orphan, clk, arst_n, done, $past(accept, vafc_pkg::LATENCY))
	`VAFC_ASSERT_DLY(a_zero_vec, clk, arst_n, accept && dx == 16'sd0 && dz == 16'sd0,
		vafc_pkg::LATENCY, angle == vafc_pkg::ANG_ZERO)
	`VAFC_ASSERT_DLY(a_first_quad, clk, arst_n, accept && dx > 16'sd0 && dz > 16'sd0,
		vafc_pkg::LATENCY, angle <= vafc_pkg::ANG_QUARTER)

endmodule
